[rtl/gctt_pkg.sv]
// Package with shared constants, codes and types of the centroid track table.
`default_nettype none
package gctt_pkg;

    // Default structural parameters.
    localparam int TRACKS_DEF     = 16;
    localparam int COORD_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF = 8;

    // Fixed field widths.
    localparam int VOTE_W  = 7;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 8;
    localparam int MS_W    = 16;
    localparam int GATE_W  = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Register indexes.
    localparam logic [2:0] REG_GATE_RADIUS = 3'd0;
    localparam logic [2:0] REG_VOTE_UP     = 3'd1;
    localparam logic [2:0] REG_VOTE_DOWN   = 3'd2;
    localparam logic [2:0] REG_DROP        = 3'd3;
    localparam logic [2:0] REG_VOTE_CAP    = 3'd4;
    localparam logic [2:0] REG_SHOW_MIN    = 3'd5;
    localparam logic [2:0] REG_GOOD_MIN    = 3'd6;

    // Register reset values.
    localparam logic [GATE_W-1:0] GATE_RADIUS_RST = 8'd20;
    localparam logic [MS_W-1:0]   VOTE_UP_RST     = 16'd100;
    localparam logic [MS_W-1:0]   VOTE_DOWN_RST   = 16'd200;
    localparam logic [MS_W-1:0]   DROP_RST        = 16'd500;
    localparam logic [VOTE_W-1:0] VOTE_CAP_RST    = 7'd64;
    localparam logic [VOTE_W-1:0] SHOW_MIN_RST    = 7'd8;
    localparam logic [VOTE_W-1:0] GOOD_MIN_RST    = 7'd15;

    // Item kinds.
    typedef enum logic [1:0] {
        MODE_BEGIN  = 2'd0,
        MODE_OBS    = 2'd1,
        MODE_END    = 2'd2,
        MODE_REPORT = 2'd3
    } mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_PLACE,
        ST_SUM
    } state_t;

endpackage
`default_nettype wire

[rtl/gctt_if.sv]
// Channel interfaces for input items and result items.
`default_nettype none
interface gctt_in_if
    import gctt_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [CW-1:0]      obs_x;
    logic [CW-1:0]      obs_y;
    logic [STAMP_W-1:0] stamp_ms;

    modport source (output valid, mode, obs_x, obs_y, stamp_ms, input ready);
    modport sink   (input valid, mode, obs_x, obs_y, stamp_ms, output ready);
endinterface

interface gctt_out_if
    import gctt_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF
);
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic [CW-1:0]     pos_x;
    logic [CW-1:0]     pos_y;
    logic [VOTE_W-1:0] favor;
    logic              is_track;
    logic              quality;
    logic              last;

    modport source (output valid, slot, pos_x, pos_y, favor, is_track, quality, last,
                    input ready);
    modport sink   (input valid, slot, pos_x, pos_y, favor, is_track, quality, last,
                    output ready);
endinterface
`default_nettype wire

[rtl/gated_centroid_track_table.sv]
// Top level of the gated centroid track table.
//
//  Channel  | Dir | Handshake          | Payload
//  in_ch    | in  | valid/ready        | mode, obs_x, obs_y, stamp_ms
//  out_ch   | out | valid/ready        | slot, pos_x, pos_y, favor, is_track, quality, last
//  APB      | in  | psel/penable/pready| seven registers at byte address 4*i
//
// Track records rotate through a ring of TRACKS cells; the head cell is updated
// once per cycle unless the ring is held, and one pass follows each accepted item.
// An observation that joins no track takes a second pass to claim a free slot.
// End of frame holds the ring at each fed track while both dividers run.
// A report closes with a summary item; a stalled output halts the ring.
// Reset clears every slot and loads the register defaults.
`default_nettype none
module gated_centroid_track_table
    import gctt_pkg::*;
#(
    parameter int TRACKS     = TRACKS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [ADDR_W-1:0]  paddr,
    input  wire [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    gctt_in_if.sink           in_ch,
    gctt_out_if.source        out_ch
);
    localparam int CW = COORD_BITS;
    localparam int NW = COUNT_BITS;
    localparam int SW = CW + NW;
    localparam int IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int DW = (2 * CW + 1 > 2 * GATE_W) ? 2 * CW + 1 : 2 * GATE_W;
    localparam int NB = SW + 2;
    localparam int DB = NW + 1;

    typedef struct packed {
        logic              act;
        logic [CW-1:0]     x;
        logic [CW-1:0]     y;
        logic [VOTE_W-1:0] votes;
        logic [STAMP_W-1:0] stime;
        logic              ever;
        logic [SW-1:0]     sx;
        logic [SW-1:0]     sy;
        logic [NW-1:0]     cnt;
    } trk_t;

    localparam int RW = $bits(trk_t);

    // Configuration registers.
    logic [GATE_W-1:0] gate_reg;
    logic [MS_W-1:0]   up_reg, down_reg, drop_reg;
    logic [VOTE_W-1:0] cap_reg, show_reg, good_reg;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg <= GATE_RADIUS_RST;
            up_reg   <= VOTE_UP_RST;
            down_reg <= VOTE_DOWN_RST;
            drop_reg <= DROP_RST;
            cap_reg  <= VOTE_CAP_RST;
            show_reg <= SHOW_MIN_RST;
            good_reg <= GOOD_MIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_GATE_RADIUS: gate_reg <= pwdata[GATE_W-1:0];
                REG_VOTE_UP:     up_reg   <= pwdata[MS_W-1:0];
                REG_VOTE_DOWN:   down_reg <= pwdata[MS_W-1:0];
                REG_DROP:        drop_reg <= pwdata[MS_W-1:0];
                REG_VOTE_CAP:    cap_reg  <= pwdata[VOTE_W-1:0];
                REG_SHOW_MIN:    show_reg <= pwdata[VOTE_W-1:0];
                REG_GOOD_MIN:    good_reg <= pwdata[VOTE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (cfg_idx)
            REG_GATE_RADIUS: prdata = DATA_W'(gate_reg);
            REG_VOTE_UP:     prdata = DATA_W'(up_reg);
            REG_VOTE_DOWN:   prdata = DATA_W'(down_reg);
            REG_DROP:        prdata = DATA_W'(drop_reg);
            REG_VOTE_CAP:    prdata = DATA_W'(cap_reg);
            REG_SHOW_MIN:    prdata = DATA_W'(show_reg);
            REG_GOOD_MIN:    prdata = DATA_W'(good_reg);
            default:         prdata = '0;
        endcase
    end

    // Ring of track cells; cell zero is the head.
    trk_t chain [TRACKS];
    trk_t head, head_next;
    logic shift;

    genvar k;
    generate
        for (k = 0; k < TRACKS; k++)
        begin : g_cell
            logic [RW-1:0] cell_in, cell_out;
            if (k == TRACKS - 1)
            begin : g_tail
                assign cell_in = head_next;
            end
            else
            begin : g_mid
                assign cell_in = chain[k+1];
            end
            gctt_cell #(.W(RW)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .rec_in  (cell_in),
                .rec_out (cell_out)
            );
            assign chain[k] = trk_t'(cell_out);
        end
    endgenerate

    assign head = chain[0];

    // Sequencer and item registers.
    state_t             state_reg, state_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic               free_reg, free_next;
    logic               matched_reg, matched_next;
    logic               qual_reg, qual_next;
    logic [1:0]         mode_reg, mode_next;
    logic [CW-1:0]      ox_reg, ox_next, oy_reg, oy_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic               in_acc, wrap;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign wrap        = (idx_reg == IW'(TRACKS - 1));

    // Output register.
    logic              out_valid_reg, out_free, out_load;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [CW-1:0]     out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [VOTE_W-1:0] out_fav_reg, out_fav_next;
    logic              out_trk_reg, out_trk_next;
    logic              out_q_reg, out_q_next;
    logic              out_last_reg, out_last_next;

    assign out_free = !out_valid_reg || out_ch.ready;

    // Gate test on the head track.
    logic [CW-1:0] dx, dy;
    logic [DW-1:0] dist2, rad2;
    logic          gate_hit;

    always_comb
    begin
        dx       = (head.x > ox_reg) ? CW'(head.x - ox_reg) : CW'(ox_reg - head.x);
        dy       = (head.y > oy_reg) ? CW'(head.y - oy_reg) : CW'(oy_reg - head.y);
        dist2    = DW'(dx) * DW'(dx) + DW'(dy) * DW'(dy);
        rad2     = DW'(gate_reg) * DW'(gate_reg);
        gate_hit = (dist2 < rad2);
    end

    // Saturating accumulation of the observation into the head track.
    trk_t          acc_rec;
    logic [SW:0]   sx_sum, sy_sum;

    always_comb
    begin
        acc_rec = head;
        sx_sum  = {1'b0, head.sx} + (SW+1)'(ox_reg);
        sy_sum  = {1'b0, head.sy} + (SW+1)'(oy_reg);
        acc_rec.sx  = sx_sum[SW] ? {SW{1'b1}} : sx_sum[SW-1:0];
        acc_rec.sy  = sy_sum[SW] ? {SW{1'b1}} : sy_sum[SW-1:0];
        acc_rec.cnt = (&head.cnt) ? head.cnt : NW'(head.cnt + 1'b1);
    end

    // Centroid dividers for both coordinates.
    logic          div_start, div_done, div_done_y;
    logic [NB-1:0] num_x, num_y, quo_x, quo_y;
    logic [DB-1:0] den;

    assign num_x = NB'({head.sx, 1'b0}) + NB'(head.cnt);
    assign num_y = NB'({head.sy, 1'b0}) + NB'(head.cnt);
    assign den   = {head.cnt, 1'b0};

    gctt_div #(.NB(NB), .DB(DB)) u_div_x (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(num_x), .den(den), .done(div_done), .quo(quo_x)
    );
    gctt_div #(.NB(NB), .DB(DB)) u_div_y (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(num_y), .den(den), .done(div_done_y), .quo(quo_y)
    );

    // End-of-frame update of a fed track.
    trk_t               end_rec;
    logic [STAMP_W-1:0] gap;
    logic [VOTE_W-1:0]  v_up;

    always_comb
    begin
        gap     = stamp_reg - head.stime;
        end_rec = head;
        end_rec.x = (|quo_x[NB-1:CW]) ? {CW{1'b1}} : quo_x[CW-1:0];
        end_rec.y = (|quo_y[NB-1:CW]) ? {CW{1'b1}} : quo_y[CW-1:0];
        v_up = head.votes;
        if (head.ever && (gap < STAMP_W'(up_reg)) && (v_up < cap_reg))
        begin
            v_up = VOTE_W'(v_up + 1'b1);
        end
        if ((!head.ever || (gap > STAMP_W'(down_reg))) && (v_up != '0))
        begin
            v_up = VOTE_W'(v_up - 1'b1);
        end
        end_rec.votes = v_up;
        end_rec.stime = stamp_reg;
        end_rec.ever  = 1'b1;
    end

    // Datapath control per state.
    always_comb
    begin
        shift         = 1'b0;
        head_next     = head;
        div_start     = 1'b0;
        out_load      = 1'b0;
        idx_next      = idx_reg;
        free_idx_next = free_idx_reg;
        free_next     = free_reg;
        matched_next  = matched_reg;
        qual_next     = qual_reg;
        mode_next     = mode_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        stamp_next    = stamp_reg;
        out_slot_next = out_slot_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_fav_next  = out_fav_reg;
        out_trk_next  = out_trk_reg;
        out_q_next    = out_q_reg;
        out_last_next = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    mode_next    = in_ch.mode;
                    ox_next      = in_ch.obs_x;
                    oy_next      = in_ch.obs_y;
                    stamp_next   = in_ch.stamp_ms;
                    idx_next     = '0;
                    free_next    = 1'b0;
                    matched_next = 1'b0;
                    qual_next    = 1'b0;
                end
            end
            ST_SCAN:
            begin
                case (mode_t'(mode_reg))
                    MODE_BEGIN:
                    begin
                        shift = 1'b1;
                        if (head.act)
                        begin
                            head_next.sx  = '0;
                            head_next.sy  = '0;
                            head_next.cnt = '0;
                        end
                    end
                    MODE_OBS:
                    begin
                        shift = 1'b1;
                        if (head.act && !matched_reg && gate_hit)
                        begin
                            head_next    = acc_rec;
                            matched_next = 1'b1;
                        end
                        else if (!head.act && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = idx_reg;
                        end
                    end
                    MODE_END:
                    begin
                        if (head.act && (head.cnt != '0))
                        begin
                            div_start = 1'b1;
                        end
                        else
                        begin
                            shift = 1'b1;
                            if (head.act && (!head.ever || (gap > STAMP_W'(drop_reg))))
                            begin
                                head_next.act = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        if (head.act && (head.votes > show_reg))
                        begin
                            if (out_free)
                            begin
                                shift         = 1'b1;
                                out_load      = 1'b1;
                                out_slot_next = SLOT_W'(idx_reg);
                                out_x_next    = head.x;
                                out_y_next    = head.y;
                                out_fav_next  = head.votes;
                                out_trk_next  = 1'b1;
                                out_q_next    = 1'b0;
                                out_last_next = 1'b0;
                                if (head.votes >= good_reg)
                                begin
                                    qual_next = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            shift = 1'b1;
                        end
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    shift     = 1'b1;
                    head_next = end_rec;
                end
            end
            ST_PLACE:
            begin
                shift = 1'b1;
                if (idx_reg == free_idx_reg)
                begin
                    head_next.act   = 1'b1;
                    head_next.votes = '0;
                    head_next.sx    = SW'(ox_reg);
                    head_next.sy    = SW'(oy_reg);
                    head_next.cnt   = NW'(1);
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_slot_next = '0;
                    out_x_next    = '0;
                    out_y_next    = '0;
                    out_fav_next  = '0;
                    out_trk_next  = 1'b0;
                    out_q_next    = qual_reg;
                    out_last_next = 1'b1;
                end
            end
            default: ;
        endcase
        if (shift)
        begin
            idx_next = wrap ? '0 : IW'(idx_reg + 1'b1);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (div_start)
                begin
                    state_next = ST_DIV;
                end
                else if (shift && wrap)
                begin
                    if (mode_reg == MODE_OBS && !matched_next && free_next)
                    begin
                        state_next = ST_PLACE;
                    end
                    else if (mode_reg == MODE_REPORT)
                    begin
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = wrap ? ST_IDLE : ST_SCAN;
                end
            end
            ST_PLACE:
            begin
                if (wrap)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            free_reg      <= 1'b0;
            matched_reg   <= 1'b0;
            qual_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            free_reg      <= free_next;
            matched_reg   <= matched_next;
            qual_reg      <= qual_next;
            out_valid_reg <= out_load || (out_valid_reg && !out_ch.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
        mode_reg     <= mode_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        stamp_reg    <= stamp_next;
        out_slot_reg <= out_slot_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_fav_reg  <= out_fav_next;
        out_trk_reg  <= out_trk_next;
        out_q_reg    <= out_q_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.slot     = out_slot_reg;
    assign out_ch.pos_x    = out_x_reg;
    assign out_ch.pos_y    = out_y_reg;
    assign out_ch.favor    = out_fav_reg;
    assign out_ch.is_track = out_trk_reg;
    assign out_ch.quality  = out_q_reg;
    assign out_ch.last     = out_last_reg;

    // Checks on the sequencer and dividers.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IW'(TRACKS - 1))
        else $error("slot index out of range");

    a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
        div_done == div_done_y)
        else $error("coordinate dividers out of step");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |-> state_reg == ST_SUM)
        else $error("summary item issued outside the summary state");
endmodule
`default_nettype wire

[rtl/gctt_cell.sv]
// One track slot cell of the rotating chain.
`default_nettype none
module gctt_cell
    import gctt_pkg::*;
#(
    parameter int W = 8
)(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         shift,
    input  wire [W-1:0] rec_in,
    output logic [W-1:0] rec_out
);
    logic [W-1:0] rec_reg;
    logic [W-1:0] rec_next;

    // Take the neighbor's record when the chain moves.
    always_comb
    begin
        rec_next = shift ? rec_in : rec_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out = rec_reg;
endmodule
`default_nettype wire

[rtl/gctt_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module gctt_div
    import gctt_pkg::*;
#(
    parameter int NB = 20,
    parameter int DB = 9
)(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    input  wire [NB-1:0] num,
    input  wire [DB-1:0] den,
    output logic         done,
    output logic [NB-1:0] quo
);
    localparam int CNT_W = $clog2(NB + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NB-1:0]    num_reg, num_next;
    logic [DB-1:0]    den_reg, den_next;
    logic [DB-1:0]    rem_reg, rem_next;
    logic [DB:0]      trial;
    logic             fits;

    // One shift-and-subtract step.
    always_comb
    begin
        trial     = {rem_reg, num_reg[NB-1]};
        fits      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DB'(trial - {1'b0, den_reg}) : DB'(trial);
            num_next = {num_reg[NB-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;
endmodule
`default_nettype wire

[sim/tb_gctt_driver.sv]
// Stimulus source that offers input items on the input channel.
`default_nettype none
module tb_gctt_driver
    import gctt_pkg::*;
(
    input  wire       clk,
    gctt_in_if.source in_ch
);
    timeunit 1ns;
    timeprecision 1ps;

    // Sender idle percentage; the top module changes it between phases.
    int idle_pct = 0;

    // Offer one item and hold it until it is accepted.
    task automatic send_item(input mode_t m, input logic [9:0] x, input logic [9:0] y,
                             input logic [31:0] stamp);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= m;
        in_ch.obs_x    <= x;
        in_ch.obs_y    <= y;
        in_ch.stamp_ms <= stamp;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // Drop valid for one cycle; the block is busy with the item anyway.
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_BEGIN;
        in_ch.obs_x    = '0;
        in_ch.obs_y    = '0;
        in_ch.stamp_ms = '0;
    end
endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for the gated centroid track table: directed table, random frames, checks.
`default_nettype none
module tb;
    import gctt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT     = 16;
    localparam int LIMIT     = 20000;
    localparam logic [9:0]  CMAX = 10'd1023;
    localparam logic [17:0] SMAX = 18'h3FFFF;
    localparam logic [7:0]  NMAX = 8'hFF;

    typedef struct packed {
        logic [7:0] slot;
        logic [9:0] pos_x;
        logic [9:0] pos_y;
        logic [6:0] favor;
        logic       is_track;
        logic       quality;
        logic       last;
    } track_rpt_t;

    typedef struct {
        mode_t       m;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [31:0] stamp;
        logic        check_summary;
        logic        want_quality;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    gctt_in_if  in_ch();
    gctt_out_if out_ch();

    gated_centroid_track_table u_top (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    tb_gctt_driver u_drv (.clk(clk), .in_ch(in_ch.source));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted table state and registers.
    logic [7:0]  gate_r;
    logic [15:0] up_ms, down_ms, drop_gap;
    logic [6:0]  cap, show_lo, good_lo;
    logic        act [NSLOT];
    logic [9:0]  tx [NSLOT], ty [NSLOT];
    logic [6:0]  votes [NSLOT];
    logic [31:0] seen_at [NSLOT];
    logic        seen [NSLOT];
    logic [17:0] sx [NSLOT], sy [NSLOT];
    logic [7:0]  cnt [NSLOT];

    track_rpt_t pending_rpts[$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  recv_idle = 0;
    int  hold_off = 0;
    int  summary_seen = 0;
    logic summary_want_q;
    logic summary_checked = 1'b0;

    function automatic logic [9:0] rounded_mean(input logic [17:0] s, input logic [7:0] n);
        logic [31:0] v;
        v = ({13'd0, s, 1'b0} + n) / {23'd0, n, 1'b0};
        return (v > CMAX) ? CMAX : v[9:0];
    endfunction

    // Apply one input item to the predicted table.
    task automatic predict_item(input mode_t m, input logic [9:0] x, input logic [9:0] y,
                                input logic [31:0] stamp);
        int free_idx;
        logic [31:0] dx, dy;
        logic [31:0] gap;
        logic q;
        int n;
        case (m)
            MODE_BEGIN:
                for (int i = 0; i < NSLOT; i++)
                    if (act[i])
                    begin
                        sx[i] = '0; sy[i] = '0; cnt[i] = '0;
                    end
            MODE_OBS:
            begin
                free_idx = -1;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (act[i])
                    begin
                        dx = (tx[i] > x) ? tx[i] - x : x - tx[i];
                        dy = (ty[i] > y) ? ty[i] - y : y - ty[i];
                        if (dx * dx + dy * dy < {24'd0, gate_r} * gate_r && free_idx != -2)
                        begin
                            sx[i] = ({1'b0, sx[i]} + x > SMAX) ? SMAX : sx[i] + x;
                            sy[i] = ({1'b0, sy[i]} + y > SMAX) ? SMAX : sy[i] + y;
                            if (cnt[i] < NMAX) cnt[i]++;
                            free_idx = -2;
                        end
                    end
                    else if (free_idx == -1)
                        free_idx = i;
                end
                if (free_idx >= 0)
                begin
                    act[free_idx] = 1'b1; votes[free_idx] = '0;
                    sx[free_idx] = x; sy[free_idx] = y; cnt[free_idx] = 8'd1;
                end
            end
            MODE_END:
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (!act[i]) continue;
                    gap = stamp - seen_at[i];
                    if (cnt[i] != 0)
                    begin
                        tx[i] = rounded_mean(sx[i], cnt[i]);
                        ty[i] = rounded_mean(sy[i], cnt[i]);
                        if (seen[i] && gap < up_ms && votes[i] < cap) votes[i]++;
                        if ((!seen[i] || gap > down_ms) && votes[i] > 0) votes[i]--;
                        seen_at[i] = stamp;
                        seen[i] = 1'b1;
                    end
                    else if (!seen[i] || gap > drop_gap)
                        act[i] = 1'b0;
                end
            default:
            begin
                q = 1'b0;
                for (int i = 0; i < NSLOT; i++)
                    if (act[i] && votes[i] > show_lo)
                    begin
                        pending_rpts.push_back('{i[7:0], tx[i], ty[i], votes[i], 1'b1, 1'b0, 1'b0});
                        if (votes[i] >= good_lo) q = 1'b1;
                    end
                pending_rpts.push_back('{8'd0, 10'd0, 10'd0, 7'd0, 1'b0, q, 1'b1});
            end
        endcase
    endtask

    task automatic reset_table();
        gate_r = GATE_RADIUS_RST; up_ms = VOTE_UP_RST; down_ms = VOTE_DOWN_RST;
        drop_gap = DROP_RST; cap = VOTE_CAP_RST; show_lo = SHOW_MIN_RST;
        good_lo = GOOD_MIN_RST;
        for (int i = 0; i < NSLOT; i++)
        begin
            act[i] = 0; tx[i] = 0; ty[i] = 0; votes[i] = 0; seen_at[i] = 0;
            seen[i] = 0; sx[i] = 0; sy[i] = 0; cnt[i] = 0;
        end
    endtask

    // Register write over APB, mirrored into the predictor.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_GATE_RADIUS: gate_r = val[7:0];
            REG_VOTE_UP:     up_ms = val[15:0];
            REG_VOTE_DOWN:   down_ms = val[15:0];
            REG_DROP:        drop_gap = val[15:0];
            REG_VOTE_CAP:    cap = val[6:0];
            REG_SHOW_MIN:    show_lo = val[6:0];
            default:         good_lo = val[6:0];
        endcase
    endtask

    task automatic push_item(input mode_t m, input logic [9:0] x, input logic [9:0] y,
                             input logic [31:0] stamp);
        predict_item(m, x, y, stamp);
        u_drv.send_item(m, x, y, stamp);
    endtask

    // Wait until every predicted result has arrived and the block has settled.
    task automatic drain();
        while (pending_rpts.size() != 0)
            @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Result checker.
    always @(posedge clk)
    begin
        track_rpt_t want;
        if (rst_n && in_ch.valid && in_ch.ready || rst_n && out_ch.valid && out_ch.ready)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_rpts.size() == 0)
            begin
                $error("result with no expectation: slot %0d", out_ch.slot);
                errors++;
            end
            else
            begin
                want = pending_rpts.pop_front();
                if (out_ch.slot !== want.slot)
                begin $error("slot exp %0d got %0d", want.slot, out_ch.slot); errors++; end
                if (out_ch.pos_x !== want.pos_x)
                begin $error("pos_x exp %0d got %0d", want.pos_x, out_ch.pos_x); errors++; end
                if (out_ch.pos_y !== want.pos_y)
                begin $error("pos_y exp %0d got %0d", want.pos_y, out_ch.pos_y); errors++; end
                if (out_ch.favor !== want.favor)
                begin $error("favor exp %0d got %0d", want.favor, out_ch.favor); errors++; end
                if (out_ch.is_track !== want.is_track)
                begin
                    $error("is_track exp %0d got %0d", want.is_track, out_ch.is_track);
                    errors++;
                end
                if (out_ch.quality !== want.quality)
                begin
                    $error("quality exp %0d got %0d", want.quality, out_ch.quality);
                    errors++;
                end
                if (out_ch.last !== want.last)
                begin $error("last exp %0d got %0d", want.last, out_ch.last); errors++; end
                // Directed rows with a typed-in summary are also checked against it.
                if (want.last && summary_checked)
                begin
                    if (out_ch.quality !== summary_want_q)
                    begin
                        $error("quality exp %0d got %0d", summary_want_q, out_ch.quality);
                        errors++;
                    end
                    summary_checked <= 1'b0;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge clk)
    begin
        if (idle_cycles >= LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Directed table: edges of the fields, every mode, reuse, gate and vote cases.
    stim_row_t directed[$];

    task automatic add_row(input mode_t m, input logic [9:0] x, input logic [9:0] y,
                           input logic [31:0] s, input logic chk, input logic q);
        directed.push_back('{m, x, y, s, chk, q});
    endtask

    // Random frame: begin, a few observations near known spots, end, sometimes report; or one noise item.
    task automatic random_frame(inout logic [31:0] clock_ms, inout int items);
        int nobs;
        logic [9:0] bx, by;
        if ($urandom_range(9) == 0)
        begin
            // Noise item of any mode with any content.
            push_item(mode_t'($urandom_range(3)), $urandom, $urandom, $urandom);
            items++;
            return;
        end
        push_item(MODE_BEGIN, $urandom, $urandom, $urandom);
        nobs = $urandom_range(5);
        for (int k = 0; k < nobs; k++)
        begin
            bx = 10'd100 * $urandom_range(4) + $urandom_range(12);
            by = 10'd100 * $urandom_range(3) + $urandom_range(12);
            if ($urandom_range(7) == 0) begin bx = $urandom; by = $urandom; end
            push_item(MODE_OBS, bx, by, $urandom);
        end
        clock_ms += ($urandom_range(5) == 0) ? $urandom : $urandom_range(120);
        push_item(MODE_END, $urandom, $urandom, clock_ms);
        items += nobs + 2;
        if ($urandom_range(2) == 0)
        begin
            push_item(MODE_REPORT, $urandom, $urandom, $urandom);
            items++;
        end
    endtask

    initial
    begin
        logic [31:0] clock_ms;
        int items;
        out_ch.ready = 1'b0;
        reset_table();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under default registers, with one vote-up case.
        add_row(MODE_REPORT, 0, 0, 0, 1'b1, 1'b0);
        add_row(MODE_OBS, 10'd0, 10'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_row(MODE_OBS, CMAX, CMAX, 0, 1'b0, 1'b0);
        add_row(MODE_OBS, 10'd5, 10'd5, 0, 1'b0, 1'b0);
        add_row(MODE_END, 0, 0, 32'd10, 1'b0, 1'b0);
        add_row(MODE_BEGIN, 0, 0, 0, 1'b0, 1'b0);
        add_row(MODE_OBS, 10'd3, 10'd4, 0, 1'b0, 1'b0);
        add_row(MODE_OBS, 10'd500, 10'd500, 0, 1'b0, 1'b0);
        add_row(MODE_END, 0, 0, 32'd50, 1'b0, 1'b0);
        add_row(MODE_BEGIN, 0, 0, 0, 1'b0, 1'b0);
        add_row(MODE_OBS, 10'd2, 10'd2, 0, 1'b0, 1'b0);
        add_row(MODE_END, 0, 0, 32'hFFFF_FFF0, 1'b0, 1'b0);
        add_row(MODE_END, 0, 0, 32'h0000_0100, 1'b0, 1'b0);
        add_row(MODE_REPORT, 0, 0, 0, 1'b1, 1'b0);
        foreach (directed[r])
        begin
            if (directed[r].check_summary)
            begin
                summary_want_q = directed[r].want_quality;
                summary_checked = 1'b1;
            end
            push_item(directed[r].m, directed[r].x, directed[r].y, directed[r].stamp);
            if (directed[r].check_summary) drain();
        end
        drain();

        // Extremes of the registers: wide gate, votes build, show threshold at zero.
        write_reg(REG_GATE_RADIUS, 32'd255);
        write_reg(REG_VOTE_UP, 32'hFFFF);
        write_reg(REG_VOTE_DOWN, 32'hFFFF);
        write_reg(REG_DROP, 32'hFFFF);
        write_reg(REG_VOTE_CAP, 32'd3);
        write_reg(REG_SHOW_MIN, 32'd0);
        write_reg(REG_GOOD_MIN, 32'd0);
        clock_ms = 32'd1000;
        items = 0;
        u_drv.idle_pct = 30;
        recv_idle = 71;
        // Many observations of one spot saturate count and sums.
        for (int k = 0; k < 4; k++)
        begin
            push_item(MODE_BEGIN, 0, 0, 0);
            for (int j = 0; j < 5; j++) push_item(MODE_OBS, CMAX, CMAX, 0);
            clock_ms += 10;
            push_item(MODE_END, 0, 0, clock_ms);
            push_item(MODE_REPORT, 0, 0, 0);
            items += 8;
        end
        push_item(MODE_BEGIN, 0, 0, 0);
        for (int j = 0; j < 260; j++) push_item(MODE_OBS, CMAX, CMAX, 0);
        push_item(MODE_END, 0, 0, clock_ms + 5);
        push_item(MODE_REPORT, 0, 0, 0);
        items += 263;
        drain();

        // Lowered cap, zero-ish gate, zero vote timings, top thresholds; long receiver hold-off.
        write_reg(REG_VOTE_CAP, 32'd1);
        write_reg(REG_GATE_RADIUS, 32'd1);
        write_reg(REG_VOTE_UP, 32'd0);
        write_reg(REG_VOTE_DOWN, 32'd0);
        write_reg(REG_DROP, 32'd0);
        write_reg(REG_SHOW_MIN, 32'd127);
        write_reg(REG_GOOD_MIN, 32'd127);
        hold_off = 600;
        for (int k = 0; k < 6; k++) push_item(MODE_REPORT, 0, 0, 0);
        items += 6;
        while (items < 360) random_frame(clock_ms, items);
        drain();

        // Default gate and drop, vote-up above vote-down, sender and receiver swapped.
        write_reg(REG_GATE_RADIUS, 32'd20);
        write_reg(REG_VOTE_UP, 32'd300);
        write_reg(REG_VOTE_DOWN, 32'd50);
        write_reg(REG_DROP, 32'd500);
        write_reg(REG_VOTE_CAP, 32'd127);
        write_reg(REG_SHOW_MIN, 32'd1);
        write_reg(REG_GOOD_MIN, 32'd4);
        u_drv.idle_pct = 71;
        recv_idle = 30;
        while (items < 410) random_frame(clock_ms, items);
        drain();

        // Quick votes, no idling.
        write_reg(REG_VOTE_UP, 32'd200);
        write_reg(REG_VOTE_DOWN, 32'd250);
        write_reg(REG_SHOW_MIN, 32'd2);
        u_drv.idle_pct = 0;
        recv_idle = 0;
        while (items < 445) random_frame(clock_ms, items);
        push_item(MODE_REPORT, 0, 0, 0);

        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
